>>> sv/assert_macros.svh
// Assertion macros shared by the files that carry concurrent checks.
// No dependencies; included by bare file name where needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in the same cycle implies the consequent in the same cycle.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bmprgb_pkg.sv
// Shared types and constants of the BMP row to RGB565 converter.
// No dependencies; imported by every module of the block.
package bmprgb_pkg;

   localparam int DATA_W  = 8;
   localparam int COLOR_W = 16;
   localparam int CSR_W   = 11;   // widest configuration register
   localparam int COL_W   = 12;   // column count, saturating above any visible width
   localparam int ROW_W   = 13;   // padded row length in bytes

   // Request opcodes.
   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_PIXEL   = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] REG_BPP     = 2'd0;
   localparam logic [1:0] REG_IS_565  = 2'd1;
   localparam logic [1:0] REG_WIDTH   = 2'd2;
   localparam logic [1:0] REG_VISIBLE = 2'd3;

   // Source depths that the block decodes.
   localparam logic [4:0] BPP_1  = 5'd1;
   localparam logic [4:0] BPP_4  = 5'd4;
   localparam logic [4:0] BPP_8  = 5'd8;
   localparam logic [4:0] BPP_16 = 5'd16;
   localparam logic [4:0] BPP_24 = 5'd24;

   typedef struct packed {
      logic [4:0]  bits_per_pixel;
      logic        is_565;
      logic [10:0] image_width;
      logic [10:0] visible_width;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [7:0]         index;
      logic [COLOR_W-1:0] color;
   } pal_wr_type;

   // One pixel on its way to the palette stage.
   typedef struct packed {
      logic               use_palette;
      logic [7:0]         index;
      logic [COLOR_W-1:0] color;
      logic               end_of_row;
      logic               last;
   } slot_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               end_of_row;
      logic               last;
   } pixel_type;

endpackage

>>> sv/bmprgb_ctrl.sv
// Row control: byte counting, 16/24-bit assembly and the per-byte pixel issuer.
// Depends on bmprgb_pkg.
module bmprgb_ctrl
   import bmprgb_pkg::*;
#(
   parameter int MAX_WIDTH    = 1024,
   parameter int PALETTE_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [7:0]          req_palette_index,
   input  logic [23:0]         req_palette_word,
   input  logic [DATA_W-1:0]   req_data_byte,
   output pal_wr_type          pal_wr,
   output logic                slot_valid,
   output slot_type            slot,
   input  logic                slot_ready
);

   typedef enum logic [2:0] {DEP_1, DEP_4, DEP_8, DEP_16, DEP_24, DEP_NONE} depth_type;
   typedef enum logic [1:0] {ITER_1, ITER_4, ITER_8, ITER_DIRECT} iter_mode_type;

   logic [ROW_W-1:0]   rbc_ff, rbc_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [1:0]         phase_ff, phase_in;
   logic [15:0]        held_ff, held_in;
   logic [3:0]         left_ff, left_in;
   logic [DATA_W-1:0]  ibyte_ff, ibyte_in;
   iter_mode_type      imode_ff, imode_in;
   logic [COLOR_W-1:0] icolor_ff, icolor_in;
   logic               ieor_ff, ieor_in;

   depth_type          depth;
   logic [10:0]        eff_width;
   logic [10:0]        vis;
   logic [16:0]        row_bits;
   logic [16:0]        row_words;
   logic [ROW_W-1:0]   row_size;
   logic [ROW_W-1:0]   rbc_next;
   logic [3:0]         npix;
   logic [3:0]         nvis;
   logic [COL_W-1:0]   room;
   logic [COL_W:0]     col_sum;
   logic [COL_W-1:0]   col_end;
   logic [COLOR_W-1:0] direct;
   logic [7:0]         lo;
   logic               accept;
   logic               fire;
   logic               pixel_go;

   assign fire      = slot_valid && slot_ready;
   assign req_stall = (left_ff > 4'd1) || ((left_ff == 4'd1) && !slot_ready);
   assign accept    = req_valid && !req_stall;

   // Palette entries are kept as RGB565.
   always_comb begin
      pal_wr.en    = accept && (req_opcode == OP_PALETTE);
      pal_wr.index = req_palette_index;
      pal_wr.color = {req_palette_word[23:19], req_palette_word[15:10],
                      req_palette_word[7:3]};
   end

   always_comb begin
      unique case (cfg.bits_per_pixel)
         BPP_1:   depth = DEP_1;
         BPP_4:   depth = (PALETTE_BITS >= 4) ? DEP_4 : DEP_NONE;
         BPP_8:   depth = (PALETTE_BITS >= 8) ? DEP_8 : DEP_NONE;
         BPP_16:  depth = DEP_16;
         BPP_24:  depth = DEP_24;
         default: depth = DEP_NONE;
      endcase
   end

   always_comb begin
      if (cfg.image_width == 11'd0) begin
         eff_width = 11'd1;
      end else if ({21'd0, cfg.image_width} > 32'(MAX_WIDTH)) begin
         eff_width = 11'(MAX_WIDTH);
      end else begin
         eff_width = cfg.image_width;
      end
      vis = (cfg.visible_width < eff_width) ? cfg.visible_width : eff_width;

      case (depth)
         DEP_1:   row_bits = {6'd0, eff_width};
         DEP_4:   row_bits = {4'd0, eff_width, 2'd0};
         DEP_8:   row_bits = {3'd0, eff_width, 3'd0};
         DEP_16:  row_bits = {2'd0, eff_width, 4'd0};
         DEP_24:  row_bits = {2'd0, eff_width, 4'd0} + {3'd0, eff_width, 3'd0};
         default: row_bits = 17'd0;
      endcase
      row_words = (row_bits + 17'd31) >> 5;
      row_size  = {row_words[ROW_W-3:0], 2'd0};
      rbc_next  = rbc_ff + ROW_W'(1);

      case (depth)
         DEP_1:   npix = 4'd8;
         DEP_4:   npix = 4'd2;
         DEP_8:   npix = 4'd1;
         DEP_16:  npix = (phase_ff != 2'd0) ? 4'd1 : 4'd0;
         DEP_24:  npix = phase_ff[1] ? 4'd1 : 4'd0;
         default: npix = 4'd0;
      endcase

      // Visible pixels always form a prefix of the pixels in one byte.
      if (col_ff < {1'b0, vis}) begin
         room = {1'b0, vis} - col_ff;
         nvis = (room < {8'd0, npix}) ? room[3:0] : npix;
      end else begin
         room = '0;
         nvis = 4'd0;
      end
      col_sum = {1'b0, col_ff} + {9'd0, npix};
      col_end = col_sum[COL_W] ? {COL_W{1'b1}} : col_sum[COL_W-1:0];

      lo = held_ff[7:0];
      if (depth == DEP_16) begin
         direct = cfg.is_565 ? {req_data_byte, lo}
                             : {req_data_byte[6:0], lo[7:5], 1'b0, lo[4:0]};
      end else begin
         direct = {req_data_byte[7:3], held_ff[15:10], lo[7:3]};
      end
   end

   assign pixel_go = accept && (req_opcode == OP_PIXEL) && (depth != DEP_NONE);

   always_comb begin
      rbc_in    = rbc_ff;
      col_in    = col_ff;
      phase_in  = phase_ff;
      held_in   = held_ff;
      left_in   = left_ff;
      ibyte_in  = ibyte_ff;
      imode_in  = imode_ff;
      icolor_in = icolor_ff;
      ieor_in   = ieor_ff;

      if (fire) begin
         left_in = left_ff - 4'd1;
         ibyte_in = (imode_ff == ITER_1) ? {ibyte_ff[6:0], 1'b0} : {ibyte_ff[3:0], 4'd0};
      end

      if (pixel_go) begin
         case (depth)
            DEP_16: begin
               if (phase_ff == 2'd0) begin
                  held_in  = {8'd0, req_data_byte};
                  phase_in = 2'd1;
               end else begin
                  phase_in = 2'd0;
               end
            end
            DEP_24: begin
               if (phase_ff == 2'd0) begin
                  held_in  = {8'd0, req_data_byte};
                  phase_in = 2'd1;
               end else if (phase_ff == 2'd1) begin
                  held_in  = {req_data_byte, held_ff[7:0]};
                  phase_in = 2'd2;
               end else begin
                  phase_in = 2'd0;
               end
            end
            default: begin
            end
         endcase

         left_in   = nvis;
         ibyte_in  = req_data_byte;
         icolor_in = direct;
         ieor_in   = (col_ff + {8'd0, nvis}) == {1'b0, vis};
         case (depth)
            DEP_1:   imode_in = ITER_1;
            DEP_4:   imode_in = ITER_4;
            DEP_8:   imode_in = ITER_8;
            default: imode_in = ITER_DIRECT;
         endcase

         if (rbc_next >= row_size) begin
            rbc_in   = '0;
            col_in   = '0;
            phase_in = 2'd0;
         end else begin
            rbc_in = rbc_next;
            col_in = col_end;
         end
      end
   end

   always_comb begin
      slot_valid       = left_ff != 4'd0;
      slot.use_palette = imode_ff != ITER_DIRECT;
      case (imode_ff)
         ITER_1:  slot.index = {7'd0, ibyte_ff[7]};
         ITER_4:  slot.index = {4'd0, ibyte_ff[7:4]};
         default: slot.index = ibyte_ff;
      endcase
      slot.color      = icolor_ff;
      slot.last       = left_ff == 4'd1;
      slot.end_of_row = (left_ff == 4'd1) && ieor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rbc_ff   <= '0;
         col_ff   <= '0;
         phase_ff <= 2'd0;
         held_ff  <= '0;
         left_ff  <= 4'd0;
      end else begin
         rbc_ff   <= rbc_in;
         col_ff   <= col_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      ibyte_ff  <= ibyte_in;
      imode_ff  <= imode_in;
      icolor_ff <= icolor_in;
      ieor_ff   <= ieor_in;
   end

endmodule

>>> sv/bmprgb_palette.sv
// Palette memory with a registered read, and the pixel stage behind it.
// Depends on bmprgb_pkg.
module bmprgb_palette
   import bmprgb_pkg::*;
#(
   parameter int PALETTE_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  pal_wr_type pal_wr,
   input  logic       slot_valid,
   input  slot_type   slot,
   output logic       slot_ready,
   output logic       px_valid,
   output pixel_type  px,
   input  logic       px_ready
);

   localparam int DEPTH = 1 << PALETTE_BITS;

   logic [COLOR_W-1:0] mem [DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;
   logic               valid_ff, valid_in;
   logic               use_pal_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               eor_ff;
   logic               last_ff;

   assign slot_ready = !valid_ff || px_ready;
   assign valid_in   = slot_ready ? slot_valid : valid_ff;

   // Read-first: a pixel issued at the edge of a palette write still sees the
   // old entry, which is the one that belongs to it.
   always_ff @(posedge clock) begin
      if (pal_wr.en) begin
         mem[pal_wr.index[PALETTE_BITS-1:0]] <= pal_wr.color;
      end
      if (slot_ready) begin
         rd_data_ff <= mem[slot.index[PALETTE_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_ready) begin
         use_pal_ff <= slot.use_palette;
         color_ff   <= slot.color;
         eor_ff     <= slot.end_of_row;
         last_ff    <= slot.last;
      end
   end

   assign px_valid      = valid_ff;
   assign px.color      = use_pal_ff ? rd_data_ff : color_ff;
   assign px.end_of_row = eor_ff;
   assign px.last       = last_ff;

endmodule

>>> sv/bmp_row_to_rgb565_converter.sv
// Top level of the BMP row to RGB565 converter: configuration registers and
// the output register. Depends on bmprgb_pkg, bmprgb_ctrl, bmprgb_palette and
// assert_macros.svh.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   opcode, palette_index, palette_word, data_byte
//   rsp       out        rsp_valid/rsp_stall   color, end_of_row, last
//   csr       in         csr_write_enable      csr_index, csr_write_data
//
// While the output is not stalled, a palette transaction or an 8, 16 or 24-bit data
// byte is taken at one per cycle, and a 1 or 4-bit byte is sent on at one visible
// pixel per cycle (up to 8 or 2), set by the single palette read port; a byte with
// no visible pixel does not hold off the next. A pixel goes from the issuer through
// the palette stage to the output register. Reset is synchronous; the palette is
// not cleared and has no clearing pass. A stalled result is held while one pixel
// waits in the palette stage and up to eight more of the following byte in the issuer.
`include "assert_macros.svh"

module bmp_row_to_rgb565_converter
   import bmprgb_pkg::*;
#(
   parameter int MAX_WIDTH    = 1024,
   parameter int PALETTE_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [7:0]         req_palette_index,
   input  logic [23:0]        req_palette_word,
   input  logic [DATA_W-1:0]  req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COLOR_W-1:0] rsp_color,
   output logic               rsp_end_of_row,
   output logic               rsp_last
);

   cfg_type    cfg_ff, cfg_in;
   pal_wr_type pal_wr;
   logic       slot_valid;
   slot_type   slot;
   logic       slot_ready;
   logic       px_valid;
   pixel_type  px;
   logic       out_ready;
   logic       rsp_valid_ff, rsp_valid_in;
   pixel_type  rsp_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_BPP:     cfg_in.bits_per_pixel = csr_write_data[4:0];
            REG_IS_565:  cfg_in.is_565         = csr_write_data[0];
            REG_WIDTH:   cfg_in.image_width    = csr_write_data;
            REG_VISIBLE: cfg_in.visible_width  = csr_write_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bits_per_pixel <= BPP_24;
         cfg_ff.is_565         <= 1'b0;
         cfg_ff.image_width    <= 11'd1024;
         cfg_ff.visible_width  <= 11'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmprgb_ctrl #(
      .MAX_WIDTH    (MAX_WIDTH),
      .PALETTE_BITS (PALETTE_BITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_palette_index (req_palette_index),
      .req_palette_word  (req_palette_word),
      .req_data_byte     (req_data_byte),
      .pal_wr            (pal_wr),
      .slot_valid        (slot_valid),
      .slot              (slot),
      .slot_ready        (slot_ready)
   );

   bmprgb_palette #(
      .PALETTE_BITS (PALETTE_BITS)
   ) u_palette (
      .clock      (clock),
      .reset      (reset),
      .pal_wr     (pal_wr),
      .slot_valid (slot_valid),
      .slot       (slot),
      .slot_ready (slot_ready),
      .px_valid   (px_valid),
      .px         (px),
      .px_ready   (out_ready)
   );

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_ready ? px_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && px_valid) begin
         rsp_ff <= px;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_color      = rsp_ff.color;
   assign rsp_end_of_row = rsp_ff.end_of_row;
   assign rsp_last       = rsp_ff.last;

   // The end of a row is always the final visible pixel of its byte.
   `ASSERT_SAME_CYCLE(a_eor_is_last, clock, reset, rsp_valid && rsp_end_of_row, rsp_last, "end_of_row without last")
   // A pixel waiting in the palette stage is never dropped while the output is stalled.
   `ASSERT_NEXT_CYCLE(a_px_held, clock, reset, px_valid && !out_ready, px_valid, "palette stage lost a pixel")
   // The input is only held off while the issuer still has pixels of a byte to send.
   `ASSERT_SAME_CYCLE(a_stall_busy, clock, reset, req_stall, slot_valid, "input stalled with an idle issuer")

endmodule
